// File: rtl/core/binary_min_heap_queue_assert.svh
// ----------------------------------------------------------------------------
// binary_min_heap_queue_assert.svh
// Assertion macros shared by the heap queue RTL. Clocked on aclk, disabled
// while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef BINARY_MIN_HEAP_QUEUE_ASSERT_SVH
`define BINARY_MIN_HEAP_QUEUE_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define BMHQ_ASSERT(name, expr, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define BMHQ_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// Constants, codes and types for the binary min-heap priority queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

    localparam int CAPACITY    = 128;
    localparam int KEY_W       = 32;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int IDX_W       = ADDR_W + 2;   // holds 2*pos+2
    localparam int COUNT_OUT_W = 8;
    localparam int STATUS_W    = 2;

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Operand pairing for the shared key comparator
    typedef enum logic [1:0] {
        CMP_KEY_PARENT,    // moving key < parent
        CMP_RIGHT_LEFT,    // right child < left child
        CMP_CHILD_KEY      // chosen child < moving key
    } cmp_sel_t;

endpackage

// File: rtl/core/binary_min_heap_queue.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Priority queue held as an array-based binary min-heap of signed keys.
//
//   Channel | Ports                                 | Direction
//   s_      | s_operation, s_key                    | in  (valid/ready)
//   m_      | m_min_key, m_status, m_count          | out (valid/ready)
//
// Insert makes one parent compare per level moved, one more when the key stops
// below the root, and none into an empty queue. Extract moves the last key to
// the root and sifts it down, comparing the children (if both exist), then the key.
// Removing the last key and refused operations skip the heap walk.
// Each level costs one read of the single-read-port heap memory and one
// pass of the shared comparator; sift-down needs two reads and two compares.
// Reset (synchronous, active low) empties the queue; memory is not cleared.
// A new transaction is taken while the previous result still waits on m_;
// the finished result holds in the response state until m_ is free.
// ----------------------------------------------------------------------------
module binary_min_heap_queue
    import bmhq_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_operation,
    input  logic [KEY_W-1:0]       s_key,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [KEY_W-1:0]       m_min_key,
    output logic [STATUS_W-1:0]    m_status,
    output logic [COUNT_OUT_W-1:0] m_count
);

    `include "binary_min_heap_queue_assert.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_CMP,
        S_DN_LAST,
        S_DN_L,
        S_DN_R,
        S_DN_K,
        S_FIN,
        S_RESP
    } state_t;

    state_t                state_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [ADDR_W-1:0]     pos_reg;
    logic [ADDR_W-1:0]     child_pos_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [KEY_W-1:0]      child_val_reg;
    logic [KEY_W-1:0]      root_reg;
    logic [KEY_W-1:0]      res_min_reg;
    status_t               res_status_reg;
    logic                  res_use_root_reg;

    logic                  m_valid_reg;
    logic [KEY_W-1:0]      m_min_key_reg;
    status_t               m_status_reg;
    logic [COUNT_OUT_W-1:0] m_count_reg;

    logic [KEY_W-1:0]      heap_mem [CAPACITY];
    logic [KEY_W-1:0]      rd_data_reg;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [KEY_W-1:0]      wr_data;

    cmp_sel_t              cmp_sel;
    logic                  cmp_less;

    logic                  accept;
    logic [ADDR_W-1:0]     ins_pos;
    logic [ADDR_W-1:0]     ins_parent;
    logic [ADDR_W-1:0]     up_parent;
    logic [ADDR_W-1:0]     up_grand;
    logic [IDX_W-1:0]      n_ext;
    logic [IDX_W-1:0]      pos_lc;
    logic [IDX_W-1:0]      pos_rc;
    logic [IDX_W-1:0]      child_lc;
    logic [CNT_W-1:0]      cnt_dec;

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;

    assign ins_pos    = count_reg[ADDR_W-1:0];
    assign ins_parent = (ins_pos - ADDR_W'(1)) >> 1;
    assign up_parent  = (pos_reg - ADDR_W'(1)) >> 1;
    assign up_grand   = (up_parent - ADDR_W'(1)) >> 1;
    assign n_ext      = IDX_W'(count_reg);
    assign pos_lc     = IDX_W'({pos_reg, 1'b1});
    assign pos_rc     = IDX_W'({pos_reg, 1'b0}) + IDX_W'(2);
    assign child_lc   = IDX_W'({child_pos_reg, 1'b1});
    assign cnt_dec    = count_reg - CNT_W'(1);

    bmhq_key_cmp u_cmp (
        .sel       (cmp_sel),
        .key_val   (key_reg),
        .mem_val   (rd_data_reg),
        .child_val (child_val_reg),
        .less      (cmp_less)
    );

    // Comparator pairing, memory read address and write port
    always_comb begin
        cmp_sel = CMP_CHILD_KEY;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = pos_reg;
        wr_data = key_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_operation == OP_INSERT) begin
                    rd_addr = ins_parent;
                end else begin
                    rd_addr = cnt_dec[ADDR_W-1:0];
                end
            end
            S_UP_CMP: begin
                cmp_sel = CMP_KEY_PARENT;
                rd_addr = up_grand;
                if (cmp_less) begin
                    wr_en   = 1'b1;
                    wr_data = rd_data_reg;
                end
            end
            S_DN_LAST: begin
                rd_addr = ADDR_W'(1);
            end
            S_DN_L: begin
                rd_addr = pos_rc[ADDR_W-1:0];
            end
            S_DN_R: begin
                cmp_sel = CMP_RIGHT_LEFT;
            end
            S_DN_K: begin
                cmp_sel = CMP_CHILD_KEY;
                rd_addr = child_lc[ADDR_W-1:0];
                if (cmp_less) begin
                    wr_en   = 1'b1;
                    wr_data = child_val_reg;
                end
            end
            S_FIN: begin
                wr_en = 1'b1;
            end
            S_RESP: begin
                rd_addr = '0;
            end
            default: begin
                rd_addr = '0;
            end
        endcase
    end

    // Heap memory: one write port, one registered read port; root mirrored
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            heap_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= heap_mem[rd_addr];
        if (wr_en && (wr_addr == '0)) begin
            root_reg <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // the response state always leaves a valid result behind
            if (m_ready && (state_reg != S_RESP)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        key_reg <= s_key;
                        if (s_operation == OP_INSERT) begin
                            pos_reg          <= ins_pos;
                            res_use_root_reg <= 1'b1;
                            if (count_reg == CNT_W'(CAPACITY)) begin
                                res_status_reg <= ST_FULL;
                                state_reg      <= S_RESP;
                            end else begin
                                res_status_reg <= ST_OK;
                                count_reg      <= count_reg + CNT_W'(1);
                                state_reg      <= (count_reg == '0) ? S_FIN : S_UP_CMP;
                            end
                        end else begin
                            res_use_root_reg <= 1'b0;
                            pos_reg          <= '0;
                            if (count_reg == '0) begin
                                res_status_reg <= ST_EMPTY;
                                res_min_reg    <= '0;
                                state_reg      <= S_RESP;
                            end else begin
                                res_status_reg <= ST_OK;
                                res_min_reg    <= root_reg;
                                count_reg      <= cnt_dec;
                                // last key removed: nothing to move
                                state_reg      <= (cnt_dec == '0) ? S_RESP : S_DN_LAST;
                            end
                        end
                    end
                end
                S_UP_CMP: begin
                    if (cmp_less) begin
                        pos_reg   <= up_parent;
                        state_reg <= (up_parent == '0) ? S_FIN : S_UP_CMP;
                    end else begin
                        state_reg <= S_FIN;
                    end
                end
                S_DN_LAST: begin
                    // last entry becomes the moving key at the root
                    key_reg   <= rd_data_reg;
                    state_reg <= (n_ext > IDX_W'(1)) ? S_DN_L : S_FIN;
                end
                S_DN_L: begin
                    child_val_reg <= rd_data_reg;
                    child_pos_reg <= pos_lc[ADDR_W-1:0];
                    state_reg     <= (pos_rc < n_ext) ? S_DN_R : S_DN_K;
                end
                S_DN_R: begin
                    // left wins ties
                    if (cmp_less) begin
                        child_val_reg <= rd_data_reg;
                        child_pos_reg <= pos_rc[ADDR_W-1:0];
                    end
                    state_reg <= S_DN_K;
                end
                S_DN_K: begin
                    if (cmp_less) begin
                        pos_reg   <= child_pos_reg;
                        state_reg <= (child_lc < n_ext) ? S_DN_L : S_FIN;
                    end else begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: begin
                    state_reg <= S_RESP;
                end
                S_RESP: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg   <= 1'b1;
                        m_min_key_reg <= res_use_root_reg ? root_reg : res_min_reg;
                        m_status_reg  <= res_status_reg;
                        m_count_reg   <= COUNT_OUT_W'(count_reg);
                        state_reg     <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_min_key = m_min_key_reg;
    assign m_status  = m_status_reg;
    assign m_count   = m_count_reg;

    `BMHQ_ASSERT(a_count_bound, count_reg <= CNT_W'(CAPACITY), "entry count above capacity")
    `BMHQ_ASSERT(a_write_in_heap, !wr_en || (CNT_W'(wr_addr) < count_reg), "write outside occupied slots")
    `BMHQ_ASSERT_NEXT(a_insert_count, accept && (s_operation == OP_INSERT) && (count_reg < CNT_W'(CAPACITY)), count_reg == $past(count_reg) + CNT_W'(1), "insert did not grow the heap")
    `BMHQ_ASSERT(a_full_count, !(m_valid && (m_status == ST_FULL)) || (m_count == COUNT_OUT_W'(CAPACITY)), "full status with heap not full")

endmodule

// File: rtl/core/bmhq_key_cmp.sv
// ----------------------------------------------------------------------------
// bmhq_key_cmp
// Shared signed key comparator with operand selection; serves both the
// sift-up and sift-down steps.
// ----------------------------------------------------------------------------
module bmhq_key_cmp
    import bmhq_pkg::*;
(
    input  cmp_sel_t           sel,
    input  logic [KEY_W-1:0]   key_val,
    input  logic [KEY_W-1:0]   mem_val,
    input  logic [KEY_W-1:0]   child_val,
    output logic               less
);

    logic signed [KEY_W-1:0] op_a;
    logic signed [KEY_W-1:0] op_b;

    always_comb begin
        unique case (sel)
            CMP_KEY_PARENT: begin
                op_a = key_val;
                op_b = mem_val;
            end
            CMP_RIGHT_LEFT: begin
                op_a = mem_val;
                op_b = child_val;
            end
            CMP_CHILD_KEY: begin
                op_a = child_val;
                op_b = key_val;
            end
            default: begin
                op_a = child_val;
                op_b = key_val;
            end
        endcase
    end

    assign less = (op_a < op_b);

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb: binary_min_heap_queue testbench
// Drives inserts and extract-mins over the s_ channel and checks every m_
// transaction against a software heap that tracks the queue contents. A short
// directed run covers the empty, last-key, extreme and duplicate-key cases.
// Random segments then fill, drain and mix the queue, with random idle bursts
// on both channels.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bmhq_pkg::*;

    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_ITEMS  = 1330;
    localparam int SEGMENT_LEN   = 200;
    localparam int QUIET_ITEMS   = 150;
    localparam int SETTLE_CYCLES = 60;
    localparam int STALL_LIMIT   = 400;

    typedef enum int {
        MIX_BALANCED,
        MIX_FILL,
        MIX_DRAIN,
        MIX_DUPLICATES
    } op_mix_t;

    typedef struct {
        logic [KEY_W-1:0]       min_key;
        status_t                status;
        logic [COUNT_OUT_W-1:0] count;
    } heap_result_t;

    // Mirror of the heap; predicts one result per accepted transaction
    class heap_queue_scoreboard;
        logic signed [KEY_W-1:0] slots [CAPACITY];
        int unsigned             held;
        heap_result_t            pending_results [$];
        int                      errors;

        function new();
            held   = 0;
            errors = 0;
        endfunction

        function void swap_slots(int a, int b);
            logic signed [KEY_W-1:0] t;
            t        = slots[a];
            slots[a] = slots[b];
            slots[b] = t;
        endfunction

        function void note_request(logic op, logic [KEY_W-1:0] key);
            heap_result_t r;
            int           pos;
            int           up;
            int           lc;
            int           pick;
            r.min_key = '0;
            r.status  = ST_OK;
            if (op == OP_INSERT) begin
                if (held >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    pos        = held;
                    slots[pos] = key;
                    while (pos > 0) begin
                        up = (pos - 1) / 2;
                        if (!(slots[pos] < slots[up])) break;
                        swap_slots(pos, up);
                        pos = up;
                    end
                    held++;
                end
                if (held > 0) r.min_key = slots[0];
            end else begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.min_key = slots[0];
                    held--;
                    slots[0] = slots[held];
                    pos      = 0;
                    forever begin
                        lc = 2 * pos + 1;
                        if (lc >= held) break;
                        pick = lc;
                        // left child wins a tie
                        if (lc + 1 < held && slots[lc + 1] < slots[lc]) pick = lc + 1;
                        if (!(slots[pick] < slots[pos])) break;
                        swap_slots(pick, pos);
                        pos = pick;
                    end
                end
            end
            r.count = COUNT_OUT_W'(held);
            pending_results.insert(pending_results.size(), r);
        endfunction

        function void check_result(logic [KEY_W-1:0] min_key, logic [STATUS_W-1:0] status,
                                   logic [COUNT_OUT_W-1:0] count);
            heap_result_t r;
            if (pending_results.size() == 0) begin
                $error("unexpected m_ transaction: min_key %0d status %0d count %0d",
                       $signed(min_key), status, count);
                errors++;
                return;
            end
            r = pending_results.pop_front();
            if (min_key !== r.min_key) begin
                $error("m_min_key: expected %0d, actual %0d", $signed(r.min_key),
                       $signed(min_key));
                errors++;
            end
            if (status !== r.status) begin
                $error("m_status: expected %0d, actual %0d", r.status, status);
                errors++;
            end
            if (count !== r.count) begin
                $error("m_count: expected %0d, actual %0d", r.count, count);
                errors++;
            end
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic                   s_operation = OP_INSERT;
    logic [KEY_W-1:0]       s_key = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b1;
    logic [KEY_W-1:0]       m_min_key;
    logic [STATUS_W-1:0]    m_status;
    logic [COUNT_OUT_W-1:0] m_count;

    heap_queue_scoreboard sb = new();
    bit                   quiet = 1'b0;
    int                   stall_cycles = 0;

    binary_min_heap_queue dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_key       (s_key),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_min_key   (m_min_key),
        .m_status    (m_status),
        .m_count     (m_count)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Result monitor and stall watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_result(m_min_key, m_status, m_count);
            if ((m_valid && m_ready) || (s_valid && s_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles + 1 >= STALL_LIMIT) begin
                $display("binary_min_heap_queue test failed");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // Receiver backpressure in random bursts
    initial begin
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (!quiet && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_item(logic op, logic [KEY_W-1:0] key);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_key       <= key;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(op, key);
    endtask

    // Sender holds off until every outstanding result is back
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending_results.size() != 0);
    endtask

    function automatic logic [KEY_W-1:0] random_key(op_mix_t mix);
        int sel;
        sel = $urandom_range(0, 7);
        if (mix == MIX_DUPLICATES && sel < 6) return KEY_W'($urandom_range(0, 7)) - 4;
        case (sel)
            0:       return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
            1:       return ($urandom_range(0, 1) != 0) ? 32'h0000_0000 : 32'hffff_ffff;
            2:       return KEY_W'($urandom_range(0, 15)) - 8;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic random_operation(op_mix_t mix);
        int roll;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  return (roll < 90) ? OP_INSERT : OP_EXTRACT;
            MIX_DRAIN: return (roll < 90) ? OP_EXTRACT : OP_INSERT;
            default:   return (roll < 50) ? OP_INSERT : OP_EXTRACT;
        endcase
    endfunction

    initial begin
        op_mix_t mix;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty, last-key, extremes and duplicates
        send_item(OP_EXTRACT, $urandom);
        send_item(OP_INSERT, 32'd5);
        send_item(OP_EXTRACT, $urandom);
        send_item(OP_EXTRACT, $urandom);
        send_item(OP_INSERT, 32'h7fff_ffff);
        send_item(OP_INSERT, 32'h8000_0000);
        send_item(OP_INSERT, 32'h0000_0000);
        send_item(OP_INSERT, 32'hffff_ffff);
        send_item(OP_INSERT, 32'd7);
        send_item(OP_INSERT, 32'd7);
        send_item(OP_INSERT, 32'd7);
        send_item(OP_INSERT, 32'd3);
        repeat (8) send_item(OP_EXTRACT, $urandom);
        send_item(OP_EXTRACT, $urandom);
        wait_drained();

        // fill, drain and mixed segments; fill runs into the full case
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % SEGMENT_LEN == 0) begin
                if (i != 0 && $urandom_range(0, 1) != 0) wait_drained();
                case ((i / SEGMENT_LEN) % 4)
                    0:       mix = MIX_BALANCED;
                    1:       mix = MIX_FILL;
                    2:       mix = MIX_DRAIN;
                    default: mix = MIX_DUPLICATES;
                endcase
            end
            if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
            send_item(random_operation(mix), random_key(mix));
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("binary_min_heap_queue test passed");
        end else begin
            $display("binary_min_heap_queue test failed");
        end
        $finish;
    end

endmodule
